// ===== hdl/umwo_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// umwo_pkg
// Shared types, constants and the sine table function of the unison
// multi-wave oscillator.
// ============================================================================
package umwo_pkg;

    // Parameter defaults
    localparam int DEF_MAX_VOICES      = 8;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_SINE_TABLE_BITS = 10;

    // Fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int VOICE_W     = 17;
    localparam int LEVEL_W     = 16;
    localparam int CENTER_W    = 31;
    localparam int SPREAD_W    = 28;
    localparam int VCOUNT_W    = 4;
    localparam int STEP32_W    = 32;
    localparam int Q15_SHIFT   = 15;
    localparam int Q15_ONE     = 32768;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;

    // Configuration port
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;

    // Quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WAVEFORM     = 3'd0,
        REG_VOICE_COUNT  = 3'd1,
        REG_LEVEL        = 3'd2,
        REG_CENTER_STEP  = 3'd3,
        REG_SPREAD_WIDTH = 3'd4
    } reg_index_t;

    typedef struct packed {
        wave_t                      waveform;
        logic [VCOUNT_W-1:0]        voice_count;
        logic [LEVEL_W-1:0]         level;
        logic [CENTER_W-1:0]        center_step;
        logic signed [SPREAD_W-1:0] spread_width;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_LOAD,
        ST_STEP_WAIT,
        ST_VOICE,
        ST_DRAIN,
        ST_MULT,
        ST_MIX_LOAD,
        ST_MIX_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic off_start;
        logic step_write;
        logic voice_go;
        logic mult;
        logic mix_start;
        logic out_write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_busy;
    } ctrl_status_t;

    // Quarter-wave sine entry k of a 2^tab_bits table: odd ninth-order Taylor
    // series in unsigned Q30, rounded to Q15 and capped at one.
    function automatic logic [VOICE_W-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned tab_bits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] s;
        t  = (64'(k) * 64'd1686629713) >> tab_bits;
        t2 = (t * t) >> 30;
        a  = 64'h4000_0000 - t2 / 64'd72;
        a  = 64'h4000_0000 - (((t2 / 64'd42) * a) >> 30);
        a  = 64'h4000_0000 - (((t2 / 64'd20) * a) >> 30);
        a  = 64'h4000_0000 - (((t2 / 64'd6) * a) >> 30);
        s  = (t * a) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return VOICE_W'(s);
    endfunction

endpackage

// ===== hdl/umwo_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// umwo_ifs
// Valid/ready channels of the oscillator: sample input and mixed output.
// ============================================================================
interface umwo_in_if import umwo_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mix_in;
    logic                       block_end;

    modport source (output valid, output mix_in, output block_end, input ready);
    modport sink   (input valid, input mix_in, input block_end, output ready);
endinterface

interface umwo_out_if import umwo_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mix_out;
    logic                       block_end_out;

    modport source (output valid, output mix_out, output block_end_out, input ready);
    modport sink   (input valid, input mix_out, input block_end_out, output ready);
endinterface

// ===== hdl/umwo_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// umwo_div
// Unsigned restoring divider, DIV_STEP_BITS quotient bits per cycle.
// ============================================================================
module umwo_div import umwo_pkg::*;
#(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int ITER  = (DIVIDEND_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_W = ITER * DIV_STEP_BITS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [PAD_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 done_reg;
    logic                 done_next;

    logic [PAD_W-1:0]     quo_work;
    logic [DIVISOR_W-1:0] rem_work;
    logic [DIVISOR_W:0]   shifted;

    // Resolve one group of quotient bits
    always_comb
    begin
        quo_work = quo_reg;
        rem_work = rem_reg;
        shifted  = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            shifted  = {rem_work, quo_work[PAD_W-1]};
            quo_work = {quo_work[PAD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg})
            begin
                shifted     = shifted - {1'b0, dvs_reg};
                quo_work[0] = 1'b1;
            end
            rem_work = shifted[DIVISOR_W-1:0];
        end
    end

    // Load operands or advance the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= PAD_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_work;
            rem_reg <= rem_work;
        end
    end

    // Count iterations, flag the last one
    always_comb
    begin
        if (start)
        begin
            cnt_next = CNT_W'(ITER);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        done_next = (cnt_reg == CNT_W'(1)) && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DIVIDEND_W-1:0];

endmodule

// ===== hdl/umwo_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// umwo_ctrl
// Sequencer: rebuilds the voice step table after reset and configuration changes,
// walks the voices of each sample, then runs scaling and output.
// ============================================================================
module umwo_ctrl import umwo_pkg::*;
#(
    parameter int MAX_VOICES = DEF_MAX_VOICES,
    localparam int NW = $clog2(MAX_VOICES + 1),
    localparam int UW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         cfg_write,
    input  logic [NW-1:0] voice_total,
    output logic [UW-1:0] voice_index,
    output ctrl_cmd_t    cmd,
    input  ctrl_status_t status
);

    ctrl_state_t   state_reg;
    ctrl_state_t   state_next;
    logic [UW-1:0] u_reg;
    logic [UW-1:0] u_next;
    logic          stale_reg;
    logic          stale_next;
    logic          last_voice;

    assign last_voice  = (u_reg == UW'(voice_total - NW'(1)));
    assign voice_index = u_reg;

    // State, voice counter and stale step table flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            u_reg     <= '0;
            stale_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
            stale_reg <= stale_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        stale_next = stale_reg | cfg_write;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    u_next      = '0;
                    state_next  = stale_reg ? ST_STEP_LOAD : ST_VOICE;
                end
            end
            ST_STEP_LOAD:
            begin
                cmd.off_start = 1'b1;
                state_next    = ST_STEP_WAIT;
            end
            ST_STEP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.step_write = 1'b1;
                    if (last_voice)
                    begin
                        u_next     = '0;
                        stale_next = 1'b0;
                        state_next = ST_VOICE;
                    end
                    else
                    begin
                        u_next     = UW'(u_reg + 1'b1);
                        state_next = ST_STEP_LOAD;
                    end
                end
            end
            ST_VOICE:
            begin
                cmd.voice_go = 1'b1;
                if (last_voice)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    u_next = UW'(u_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_MIX_LOAD;
            end
            ST_MIX_LOAD:
            begin
                cmd.mix_start = 1'b1;
                state_next    = ST_MIX_WAIT;
            end
            ST_MIX_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/umwo_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// umwo_dp
// Datapath: voice step table, phase accumulators, waveform generation,
// voice sum, level scaling with shared divider, saturation, output register.
// ============================================================================
module umwo_dp import umwo_pkg::*;
#(
    parameter int MAX_VOICES      = DEF_MAX_VOICES,
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    localparam int NW = $clog2(MAX_VOICES + 1),
    localparam int UW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic [NW-1:0]              voice_total,
    input  logic [UW-1:0]              voice_index,
    input  ctrl_cmd_t                  cmd,
    output ctrl_status_t               status,
    input  logic signed [SAMPLE_W-1:0] mix_in,
    input  logic                       block_end,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] mix_out,
    output logic                       block_end_out
);

    localparam int TAB_N      = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int IDX_W      = SINE_TABLE_BITS + 2;
    localparam int SUM_W      = VOICE_W + $clog2(MAX_VOICES + 1);
    localparam int PROD_W     = SUM_W + LEVEL_W + 1;
    localparam int NUM_W      = PROD_W + 1;
    localparam int XW         = NUM_W - Q15_SHIFT;
    localparam int FW         = NW + 2;
    localparam int OFF_PROD_W = SPREAD_W + FW;
    localparam int OFF_MAG_W  = OFF_PROD_W - 1;
    localparam int DIV_W      = (OFF_MAG_W > XW) ? OFF_MAG_W : XW;
    localparam int DVS_W      = NW + 1;
    localparam int QW         = DIV_W + 1;
    localparam int MIX_W      = QW + 1;

    // ------------------------------------------------------------------
    // Quarter-wave sine table
    // ------------------------------------------------------------------
    logic [VOICE_W-1:0] sine_rom [TAB_N+1];

    for (genvar k = 0; k <= TAB_N; k++)
    begin : g_sine_rom
        assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [DVS_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quotient;
    logic                        div_neg_reg;
    logic signed [QW-1:0]        q_signed;

    umwo_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign q_signed = div_neg_reg ? -QW'({1'b0, div_quotient}) : QW'({1'b0, div_quotient});

    // ------------------------------------------------------------------
    // Voice step offset: spread * (2u - (n - 1)) / (2 (n - 1)), toward zero
    // ------------------------------------------------------------------
    logic signed [SPREAD_W-1:0]   spread;
    logic signed [FW-1:0]         factor;
    logic signed [OFF_PROD_W-1:0] off_prod;
    logic [OFF_MAG_W-1:0]         off_mag;
    logic signed [QW-1:0]         off_val;
    logic [STEP32_W-1:0]          step32;
    logic [PHASE_BITS+STEP32_W-1:0] step_wide;
    logic [PHASE_BITS-1:0]        step_scaled;

    assign spread   = cfg.spread_width;
    assign factor   = FW'({voice_index, 1'b0}) - FW'(voice_total) + FW'(1);
    assign off_prod = OFF_PROD_W'(spread) * OFF_PROD_W'(factor);
    assign off_mag  = off_prod[OFF_PROD_W-1] ? OFF_MAG_W'(-off_prod) : OFF_MAG_W'(off_prod);
    assign off_val  = (voice_total == NW'(1)) ? '0 : q_signed;
    assign step32   = STEP32_W'(cfg.center_step) + STEP32_W'(off_val);
    // Scale the 32-bit step to the phase width
    assign step_wide   = {step32, PHASE_BITS'(0)};
    assign step_scaled = step_wide[PHASE_BITS+STEP32_W-1 -: PHASE_BITS];

    // ------------------------------------------------------------------
    // Level scaling: floor((sum * level + n * 16384) / (n * 32768))
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [LEVEL_W:0]  level_s;
    logic [NUM_W-1:0]         mix_num;
    logic [XW-1:0]            mix_x;
    logic [XW-1:0]            mix_mag;

    assign level_s = {1'b0, cfg.level};
    assign mix_num = NUM_W'(prod_reg) + NUM_W'({voice_total, 14'b0});
    assign mix_x   = mix_num[NUM_W-1:Q15_SHIFT];
    // Negative: floor division as -ceil(|x| / n), |x| + n - 1 = ~x + n
    assign mix_mag = mix_x[XW-1] ? (~mix_x + XW'(voice_total)) : mix_x;

    // Route operands to the divider
    always_comb
    begin
        div_start = cmd.off_start | cmd.mix_start;
        if (cmd.off_start)
        begin
            div_dividend = DIV_W'(off_mag);
            div_divisor  = {voice_total - NW'(1), 1'b0};
        end
        else
        begin
            div_dividend = DIV_W'(mix_mag);
            div_divisor  = DVS_W'(voice_total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.off_start)
        begin
            div_neg_reg <= off_prod[OFF_PROD_W-1];
        end
        else if (cmd.mix_start)
        begin
            div_neg_reg <= mix_x[XW-1];
        end
    end

    // ------------------------------------------------------------------
    // Step table and phase accumulators
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] step_tbl_reg [MAX_VOICES];
    logic [PHASE_BITS-1:0] phase_reg [MAX_VOICES];
    logic [PHASE_BITS-1:0] phase_cur;

    assign phase_cur = phase_reg[voice_index];

    always_ff @(posedge clk)
    begin
        if (cmd.step_write)
        begin
            step_tbl_reg[voice_index] <= step_scaled;
        end
    end

    // Advance the active voice; idle voices hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                phase_reg[i] <= '0;
            end
        end
        else if (cmd.voice_go)
        begin
            phase_reg[voice_index] <= phase_cur + step_tbl_reg[voice_index];
        end
    end

    // ------------------------------------------------------------------
    // Waveform, first stage: table address and direct shapes
    // ------------------------------------------------------------------
    logic [15:0]                p16;
    logic [IDX_W-1:0]           sine_idx;
    logic [1:0]                 quad;
    logic [ADDR_W-1:0]          rom_addr;
    logic [17:0]                p16_x2;
    logic signed [VOICE_W-1:0]  shape_val;

    assign p16      = phase_cur[PHASE_BITS-1 -: 16];
    assign sine_idx = phase_cur[PHASE_BITS-1 -: IDX_W];
    assign quad     = sine_idx[IDX_W-1 -: 2];
    // Mirror the address in the second and fourth quadrant
    assign rom_addr = quad[0] ? (ADDR_W'(TAB_N) - {1'b0, sine_idx[SINE_TABLE_BITS-1:0]})
                              : {1'b0, sine_idx[SINE_TABLE_BITS-1:0]};
    assign p16_x2   = 18'({p16, 1'b0});

    always_comb
    begin
        case (cfg.waveform)
            WAVE_SAW:
            begin
                shape_val = VOICE_W'(18'({2'b0, p16}) - 18'(Q15_ONE));
            end
            WAVE_SQUARE:
            begin
                shape_val = p16[15] ? VOICE_W'(-Q15_ONE) : VOICE_W'(Q15_ONE);
            end
            WAVE_TRIANGLE:
            begin
                shape_val = p16[15] ? VOICE_W'(18'(3 * Q15_ONE) - p16_x2)
                                    : VOICE_W'(p16_x2 - 18'(Q15_ONE));
            end
            default:
            begin
                shape_val = '0;
            end
        endcase
    end

    logic [VOICE_W-1:0]        rom_reg;
    logic                      sine_neg_reg;
    logic signed [VOICE_W-1:0] shape_reg;
    logic                      acc_en_reg;

    always_ff @(posedge clk)
    begin
        rom_reg      <= sine_rom[rom_addr];
        sine_neg_reg <= quad[1];
        shape_reg    <= shape_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.voice_go;
        end
    end

    // ------------------------------------------------------------------
    // Waveform, second stage: sign the sine and accumulate
    // ------------------------------------------------------------------
    logic signed [VOICE_W-1:0] voice_val;

    always_comb
    begin
        if (cfg.waveform == WAVE_SINE)
        begin
            voice_val = sine_neg_reg ? -signed'(rom_reg) : signed'(rom_reg);
        end
        else
        begin
            voice_val = shape_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sum_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(voice_val);
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(level_s);
        end
    end

    // ------------------------------------------------------------------
    // Input capture, mix and saturation, output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] mix_in_reg;
    logic                       block_end_reg;
    logic signed [MIX_W-1:0]    mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;
    logic signed [SAMPLE_W-1:0] mix_out_reg;
    logic                       block_end_out_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mix_in_reg    <= mix_in;
            block_end_reg <= block_end;
        end
    end

    assign mix_sum = MIX_W'(mix_in_reg) + MIX_W'(q_signed);

    always_comb
    begin
        if (mix_sum > MIX_W'(SAMPLE_MAX))
        begin
            mix_sat = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (mix_sum < MIX_W'(SAMPLE_MIN))
        begin
            mix_sat = SAMPLE_W'(SAMPLE_MIN);
        end
        else
        begin
            mix_sat = SAMPLE_W'(mix_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_write)
        begin
            mix_out_reg       <= mix_sat;
            block_end_out_reg <= block_end_reg;
        end
    end

    // Hold the beat until the sink takes it
    always_comb
    begin
        if (cmd.out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mix_out         = mix_out_reg;
    assign block_end_out   = block_end_out_reg;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg & ~out_ready;

endmodule

// ===== hdl/unison_multiwave_oscillator_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// unison_multiwave_oscillator_unit
// Unison DDS oscillator that adds a scaled multi-voice waveform into a
// stream of samples.
// ============================================================================
// Each input beat is one sample tick and yields one output beat. The voices
// of a beat pass one after another through the single phase/waveform unit,
// and the shared radix-16 divider then divides the scaled sum by n, where n
// is the clamped voice count; the divider is 33 bits wide at default
// parameters. The first beat after reset and the first beat after any
// configuration write also rebuild the per-voice step table through the same
// divider. A new input beat is taken while the previous result still waits
// in the output register.
// ============================================================================
module unison_multiwave_oscillator_unit import umwo_pkg::*;
#(
    parameter int MAX_VOICES      = DEF_MAX_VOICES,
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    umwo_in_if.sink                sample_in,
    umwo_out_if.source             sample_out,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NW = $clog2(MAX_VOICES + 1);
    localparam int UW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    logic [NW-1:0] voice_total;
    logic [UW-1:0] voice_index;
    ctrl_cmd_t     cmd;
    ctrl_status_t  status;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WAVEFORM:     cfg_next.waveform     = wave_t'(cfg_data[1:0]);
                REG_VOICE_COUNT:  cfg_next.voice_count  = cfg_data[VCOUNT_W-1:0];
                REG_LEVEL:        cfg_next.level        = cfg_data[LEVEL_W-1:0];
                REG_CENTER_STEP:  cfg_next.center_step  = cfg_data[CENTER_W-1:0];
                REG_SPREAD_WIDTH: cfg_next.spread_width = signed'(cfg_data[SPREAD_W-1:0]);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveform     <= WAVE_SINE;
            cfg_reg.voice_count  <= VCOUNT_W'(1);
            cfg_reg.level        <= LEVEL_W'(Q15_ONE);
            cfg_reg.center_step  <= '0;
            cfg_reg.spread_width <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Clamp the voice count to 1 .. MAX_VOICES
    always_comb
    begin
        if (cfg_reg.voice_count == '0)
        begin
            voice_total = NW'(1);
        end
        else if (32'(cfg_reg.voice_count) > 32'(MAX_VOICES))
        begin
            voice_total = NW'(MAX_VOICES);
        end
        else
        begin
            voice_total = NW'(cfg_reg.voice_count);
        end
    end

    umwo_ctrl #(
        .MAX_VOICES (MAX_VOICES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sample_in.valid),
        .in_ready    (sample_in.ready),
        .cfg_write   (cfg_wr_en),
        .voice_total (voice_total),
        .voice_index (voice_index),
        .cmd         (cmd),
        .status      (status)
    );

    umwo_dp #(
        .MAX_VOICES      (MAX_VOICES),
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .voice_total   (voice_total),
        .voice_index   (voice_index),
        .cmd           (cmd),
        .status        (status),
        .mix_in        (sample_in.mix_in),
        .block_end     (sample_in.block_end),
        .out_ready     (sample_out.ready),
        .out_valid     (sample_out.valid),
        .mix_out       (sample_out.mix_out),
        .block_end_out (sample_out.block_end_out)
    );

endmodule
